>>> rtl/fbmvn_pkg.sv
// fbmvn_pkg: shared constants and helpers of the fBm value noise block.
// Used by fbmvn_octave, fbm_value_noise_3d_top and tb; no dependencies.
`default_nettype none

package fbmvn_pkg;

    localparam int N_OCT       = 8;   // octave lanes
    localparam int VAL_W       = 24;  // Q0.24 lattice and blend values
    localparam int SM_W        = 17;  // smoothstep weight, 0..65536
    localparam int AMP_W       = 16;
    localparam int NORM_W      = 19;
    localparam int TERM_W      = AMP_W + VAL_W;
    localparam int SUM_W       = TERM_W + 3;
    localparam int Q_W         = 16;
    localparam int LANE_STAGES = 8;
    localparam int NSTG        = LANE_STAGES + 3 + Q_W;

    localparam logic [3:0] CFG_OCTAVES = 4'd0;
    localparam logic [3:0] CFG_LACUN   = 4'd1;
    localparam logic [3:0] CFG_GAIN    = 4'd2;
    localparam logic [3:0] CFG_SEED    = 4'd3;

    localparam logic [3:0]  OCT_RST  = 4'd5;
    localparam logic [11:0] LAC_RST  = 12'd512;
    localparam logic [15:0] GAIN_RST = 16'd32768;
    localparam logic [31:0] SEED_RST = 32'd1337;

    localparam logic [31:0]      FREQ_ONE = 32'h0001_0000;
    localparam logic [AMP_W-1:0] AMP_ONE  = 16'd32768;

    localparam logic [31:0] HASH_A  = 32'h9E37_79B9;
    localparam logic [31:0] HASH_C1 = 32'd374761393;
    localparam logic [31:0] HASH_P2 = 32'd2654435761;
    localparam logic [31:0] HASH_C3 = 32'h85EB_CA6B;
    localparam logic [31:0] HASH_P4 = 32'd2246822519;
    localparam logic [31:0] HASH_C5 = 32'hC2B2_AE35;

    // (a*(1-s) + b*s) in Q1.16 weights, truncated
    function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b,
                                               input logic [SM_W-1:0] s);
        logic [SM_W-1:0] w;
        logic [40:0]     acc;
        w   = 17'h10000 - s;
        acc = 41'(a) * 41'(w) + 41'(b) * 41'(s);
        return acc[39:16];
    endfunction

endpackage

`default_nettype wire

>>> rtl/fbmvn_octave.sv
// fbmvn_octave: one octave of value noise, eight register stages.
// Scale, cell hash of all eight corners, smoothstep and trilinear blend.
// Depends on fbmvn_pkg.
`default_nettype none

module fbmvn_octave (
    input  wire logic                        aclk,
    input  wire logic                        adv,
    input  wire logic [31:0]                 coord_x,
    input  wire logic [31:0]                 coord_y,
    input  wire logic [31:0]                 coord_z,
    input  wire logic [31:0]                 freq,
    input  wire logic [31:0]                 seed,
    output logic      [fbmvn_pkg::VAL_W-1:0] noise
);
    import fbmvn_pkg::*;

    logic [31:0]       crd [3];
    logic [63:0]       p_reg [3];
    logic [31:0]       ax_reg [3];
    logic [15:0]       t_reg [3];
    logic [15:0]       t2_reg [3];
    logic [31:0]       g_reg [2];
    logic [31:0]       ay3_reg, az3_reg, az4_reg;
    logic [SM_W-1:0]   s3_reg [3];
    logic [SM_W-1:0]   s4_reg [3];
    logic [SM_W-1:0]   s5_reg [3];
    logic [SM_W-1:0]   s6y_reg, s6z_reg, s7z_reg;
    logic [31:0]       k_reg [4];
    logic [VAL_W-1:0]  corner_reg [8];
    logic [VAL_W-1:0]  xb_reg [4];
    logic [VAL_W-1:0]  yb_reg [2];
    logic [VAL_W-1:0]  noise_reg;

    logic [31:0]       h1_w [2];
    logic [31:0]       g_next [2];
    logic [31:0]       h2_w [4];
    logic [31:0]       k_next [4];
    logic [31:0]       h3_w [8];
    logic [17:0]       w_w [3];
    logic [33:0]       sp_w [3];
    logic [64:0]       prod_w [3];
    logic [31:0]       sq_w [3];

    assign crd[0] = coord_x;
    assign crd[1] = coord_y;
    assign crd[2] = coord_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod_w[a] = $signed({{33{crd[a][31]}}, crd[a]}) * $signed({33'b0, freq});
            sq_w[a]   = {16'b0, p_reg[a][31:16]} * {16'b0, p_reg[a][31:16]};
            w_w[a]    = 18'h30000 - {1'b0, t_reg[a], 1'b0};
            sp_w[a]   = {18'b0, t2_reg[a]} * {16'b0, w_w[a]};
        end
        // hash is A*c + const per axis; the +1 corner adds A
        for (int jx = 0; jx < 2; jx++) begin
            h1_w[jx]   = seed ^ (HASH_C1 + ax_reg[0] + ((jx == 1) ? HASH_A : 32'd0));
            g_next[jx] = (h1_w[jx] ^ (h1_w[jx] >> 16)) * HASH_P2;
        end
        for (int j = 0; j < 4; j++) begin
            h2_w[j]   = g_reg[j / 2] ^ (HASH_C3 + ay3_reg + ((j % 2 == 1) ? HASH_A : 32'd0));
            k_next[j] = (h2_w[j] ^ (h2_w[j] >> 13)) * HASH_P4;
        end
        for (int c = 0; c < 8; c++) begin
            h3_w[c] = k_reg[c / 2] ^ (HASH_C5 + az4_reg + ((c % 2 == 1) ? HASH_A : 32'd0));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                p_reg[a]  <= prod_w[a][63:0];
                ax_reg[a] <= p_reg[a][63:32] * HASH_A;
                t_reg[a]  <= p_reg[a][31:16];
                t2_reg[a] <= sq_w[a][31:16];
                s3_reg[a] <= sp_w[a][32:16];
                s4_reg[a] <= s3_reg[a];
                s5_reg[a] <= s4_reg[a];
            end
            g_reg   <= g_next;
            ay3_reg <= ax_reg[1];
            az3_reg <= ax_reg[2];
            k_reg   <= k_next;
            az4_reg <= az3_reg;
            for (int c = 0; c < 8; c++) begin
                corner_reg[c] <= h3_w[c][23:0] ^ {8'b0, h3_w[c][31:16]};
            end
            for (int j = 0; j < 4; j++) begin
                xb_reg[j] <= blend(corner_reg[j], corner_reg[4 + j], s5_reg[0]);
            end
            s6y_reg <= s5_reg[1];
            s6z_reg <= s5_reg[2];
            for (int jz = 0; jz < 2; jz++) begin
                yb_reg[jz] <= blend(xb_reg[jz], xb_reg[2 + jz], s6y_reg);
            end
            s7z_reg   <= s6z_reg;
            noise_reg <= blend(yb_reg[0], yb_reg[1], s7z_reg);
        end
    end

    assign noise = noise_reg;

endmodule

`default_nettype wire

>>> rtl/fbm_value_noise_3d_top.sv
// fbm_value_noise_3d_top: fBm value noise over a 3D lattice, one sample per cycle when not stalled.
// Holds the registers, per-octave tables, octave lanes, sum and divider.
// Depends on fbmvn_pkg and fbmvn_octave.
//
// Input channel s_*: one signed Q16.16 point per transfer. Result channel m_*:
// one unsigned Q0.16 noise value per transfer, in input order.
// One item per cycle is sustained outside output stalls and table rebuilds.
// Eight octave lanes run in parallel (8 stages each), then an amplitude
// weighting stage, a two-stage sum and a 16-stage restoring divider by the
// amplitude sum, one quotient bit per stage.
// Frequency and amplitude of each octave and their sum come from a table that
// is rebuilt after reset and after every register write; s_ready is low
// during the rebuild.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) restores register defaults and empties
// the pipeline.
`default_nettype none

module fbm_value_noise_3d_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_coord_x,
    input  wire logic [31:0] s_coord_y,
    input  wire logic [31:0] s_coord_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [fbmvn_pkg::Q_W-1:0] m_noise_value,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import fbmvn_pkg::*;

    logic [3:0]        oct_cnt_reg;
    logic [11:0]       lac_reg;
    logic [15:0]       gain_reg;
    logic [31:0]       seed_reg;
    logic [3:0]        n_eff;

    logic              upd_busy_reg;
    logic [2:0]        upd_idx_reg;
    logic [31:0]       freq_run_reg;
    logic [AMP_W-1:0]  amp_run_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [31:0]       freq_tab_reg [N_OCT];
    logic [AMP_W-1:0]  amp_tab_reg [N_OCT];
    logic [43:0]       fstep_w;
    logic [31:0]       astep_w;

    logic              adv;
    logic [NSTG-1:0]   vld_reg;
    logic [VAL_W-1:0]  noise_w [N_OCT];
    logic [TERM_W-1:0] term_reg [N_OCT];
    logic [TERM_W:0]   pair_reg [4];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]    quo_reg [Q_W];
    logic [SUM_W-1:0]  rin_w [Q_W];
    logic [SUM_W-1:0]  dsh_w [Q_W];

    // ---- configuration registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_cnt_reg <= OCT_RST;
            lac_reg     <= LAC_RST;
            gain_reg    <= GAIN_RST;
            seed_reg    <= SEED_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OCTAVES: oct_cnt_reg <= cfg_wdata[3:0];
                CFG_LACUN:   lac_reg     <= cfg_wdata[11:0];
                CFG_GAIN:    gain_reg    <= cfg_wdata[15:0];
                CFG_SEED:    seed_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (oct_cnt_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (oct_cnt_reg > 4'(N_OCT)) begin
            n_eff = 4'(N_OCT);
        end else begin
            n_eff = oct_cnt_reg;
        end
    end

    // ---- per-octave frequency / amplitude table, one octave per cycle ----
    assign fstep_w = {12'b0, freq_run_reg} * {32'b0, lac_reg};
    assign astep_w = {16'b0, amp_run_reg} * {16'b0, gain_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            upd_busy_reg <= 1'b1;
            upd_idx_reg  <= '0;
            freq_run_reg <= FREQ_ONE;
            amp_run_reg  <= AMP_ONE;
            norm_reg     <= '0;
        end else if (upd_busy_reg) begin
            freq_run_reg <= fstep_w[39:8];
            amp_run_reg  <= astep_w[31:16];
            if ({1'b0, upd_idx_reg} < n_eff) begin
                norm_reg <= norm_reg + NORM_W'(amp_run_reg);
            end
            upd_idx_reg <= upd_idx_reg + 3'd1;
            if (upd_idx_reg == 3'(N_OCT - 1)) begin
                upd_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_busy_reg) begin
            freq_tab_reg[upd_idx_reg] <= freq_run_reg;
            amp_tab_reg[upd_idx_reg]  <= amp_run_reg;
        end
    end

    // ---- pipeline control: the whole pipe moves or holds together ----
    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv && !upd_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid && s_ready};
        end
    end

    // ---- octave lanes ----
    for (genvar g = 0; g < N_OCT; g++) begin : g_oct
        fbmvn_octave u_oct (
            .aclk    (aclk),
            .adv     (adv),
            .coord_x (s_coord_x),
            .coord_y (s_coord_y),
            .coord_z (s_coord_z),
            .freq    (freq_tab_reg[g]),
            .seed    (seed_reg),
            .noise   (noise_w[g])
        );
    end

    // ---- weighting and sum ----
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_OCT; i++) begin
                term_reg[i] <= (4'(i) < n_eff) ?
                               TERM_W'(amp_tab_reg[i]) * TERM_W'(noise_w[i]) : '0;
            end
            for (int j = 0; j < 4; j++) begin
                pair_reg[j] <= {1'b0, term_reg[2*j]} + {1'b0, term_reg[2*j+1]};
            end
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1])
                     + SUM_W'(pair_reg[2]) + SUM_W'(pair_reg[3]);
        end
    end

    // ---- restoring divider: sum / (norm * 256), one quotient bit per stage ----
    // The weighted mean stays below 2^24, so 16 quotient bits always suffice.
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            rin_w[k] = (k == 0) ? sum_reg : rem_reg[(k == 0) ? 0 : k - 1];
            dsh_w[k] = SUM_W'({norm_reg, 8'b0}) << (Q_W - 1 - k);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < Q_W; k++) begin
                if (rin_w[k] >= dsh_w[k]) begin
                    rem_reg[k] <= rin_w[k] - dsh_w[k];
                    quo_reg[k] <= ((k == 0) ? '0 : quo_reg[(k == 0) ? 0 : k - 1])
                                  | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    rem_reg[k] <= rin_w[k];
                    quo_reg[k] <= (k == 0) ? '0 : quo_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign m_valid       = vld_reg[NSTG-1];
    assign m_noise_value = quo_reg[Q_W-1];

    // ---- checks ----
    a_no_take_in_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_busy_reg |-> !s_ready)
        else $error("input taken during table rebuild");

    a_norm_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd_busy_reg |-> (norm_reg >= NORM_W'(AMP_ONE)))
        else $error("amplitude sum below first octave amplitude");

    a_stall_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(vld_reg) && $stable(sum_reg)))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking bench for fbm_value_noise_3d_top (fBm value noise, Q16.16 in, Q0.16 out).
// Depends on fbmvn_pkg and the block's RTL; a scoreboard class predicts each noise value.
`default_nettype none

class noise_scoreboard;
    logic [3:0]  octaves;
    logic [11:0] lacun;
    logic [15:0] gain;
    logic [31:0] seed;
    logic [15:0] pending[$];
    int          errors;

    function new();
        errors = 0;
        set_defaults();
    endfunction

    function void set_defaults();
        octaves = fbmvn_pkg::OCT_RST;
        lacun   = fbmvn_pkg::LAC_RST;
        gain    = fbmvn_pkg::GAIN_RST;
        seed    = fbmvn_pkg::SEED_RST;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] val);
        case (idx)
            fbmvn_pkg::CFG_OCTAVES: octaves = val[3:0];
            fbmvn_pkg::CFG_LACUN:   lacun   = val[11:0];
            fbmvn_pkg::CFG_GAIN:    gain    = val[15:0];
            fbmvn_pkg::CFG_SEED:    seed    = val;
            default: ;
        endcase
    endfunction

    function logic [23:0] corner_hash(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [31:0] h;
        h = seed;
        h ^= 32'd374761393 + 32'h9E3779B9 * x;
        h = (h ^ (h >> 16)) * 32'd2654435761;
        h ^= 32'h85EBCA6B + 32'h9E3779B9 * y;
        h = (h ^ (h >> 13)) * 32'd2246822519;
        h ^= 32'hC2B2AE35 + 32'h9E3779B9 * z;
        h ^= h >> 16;
        return h[23:0];
    endfunction

    function logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
        return (a * (64'd65536 - s) + b * s) >> 16;
    endfunction

    function logic [63:0] smooth(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> 16;
        return (t2 * (64'd196608 - 2 * t)) >> 16;
    endfunction

    function logic [15:0] noise_of(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        logic [31:0] crd[3];
        logic [31:0] lat[3];
        logic [63:0] sw[3];
        logic [63:0] prod, amp, sum, norm, v00, v10, v01, v11, vy0, vy1, q;
        logic [31:0] freq;
        int          n;
        crd[0] = px; crd[1] = py; crd[2] = pz;
        n = (octaves < 1) ? 1 : (octaves > 8) ? 8 : octaves;
        freq = fbmvn_pkg::FREQ_ONE;
        amp = 64'd32768; sum = 0; norm = 0;
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) begin
                prod = $signed({{32{crd[a][31]}}, crd[a]}) * $signed({32'd0, freq});
                lat[a] = prod[63:32];
                sw[a] = smooth({48'd0, prod[31:16]});
            end
            v00 = mix(corner_hash(lat[0], lat[1], lat[2]),
                      corner_hash(lat[0] + 1, lat[1], lat[2]), sw[0]);
            v10 = mix(corner_hash(lat[0], lat[1] + 1, lat[2]),
                      corner_hash(lat[0] + 1, lat[1] + 1, lat[2]), sw[0]);
            v01 = mix(corner_hash(lat[0], lat[1], lat[2] + 1),
                      corner_hash(lat[0] + 1, lat[1], lat[2] + 1), sw[0]);
            v11 = mix(corner_hash(lat[0], lat[1] + 1, lat[2] + 1),
                      corner_hash(lat[0] + 1, lat[1] + 1, lat[2] + 1), sw[0]);
            vy0 = mix(v00, v10, sw[1]);
            vy1 = mix(v01, v11, sw[1]);
            sum += amp * mix(vy0, vy1, sw[2]);
            norm += amp;
            amp = (amp * gain) >> 16;
            freq = 32'(({32'd0, freq} * lacun) >> 8);
        end
        q = (norm != 0) ? (sum / norm) >> 8 : 0;
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    function void note_input(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending = {pending, noise_of(x, y, z)};
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (pending.size() == 0) begin
            $error("noise_value: unexpected result %0d", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam logic [3:0] CFG_UNUSED = 4'd9;  // index past the register list

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_coord_x = 0, s_coord_y = 0, s_coord_z = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_noise_value;
    logic        cfg_we = 0;
    logic [3:0]  cfg_index = 0;
    logic [31:0] cfg_wdata = 0;

    noise_scoreboard sb = new();
    int  send_idle_pct = 0, recv_stall_pct = 0;
    bit  hold_off = 0;
    longint cycles = 0;

    always #6 aclk = ~aclk;

    fbm_value_noise_3d_top i_dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: sample at rising edge, choose ready at falling edge
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_noise_value);

    always @(negedge aclk)
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // valid stays up after a transfer so the next point can follow at once;
    // drain() or an idle cycle takes it down
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1; s_coord_x <= x; s_coord_y <= y; s_coord_z <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(x, y, z);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
        endcase
    endfunction

    task automatic random_config();
        write_reg(fbmvn_pkg::CFG_OCTAVES, $urandom_range(15));
        write_reg(fbmvn_pkg::CFG_LACUN, $urandom_range(3) == 0 ? $urandom_range(4095)
                                                               : $urandom_range(256, 2048));
        write_reg(fbmvn_pkg::CFG_GAIN, $urandom);
        write_reg(fbmvn_pkg::CFG_SEED, $urandom);
    endtask

    initial begin
        logic [31:0] ext[5];
        ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_8000};
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: coordinate extremes at reset settings
        for (int i = 0; i < 5; i++) send_point(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
        drain();
        // zero octaves, octaves above the lane count, zero lacunarity, extreme gain
        write_reg(fbmvn_pkg::CFG_OCTAVES, 0);
        write_reg(fbmvn_pkg::CFG_LACUN, 0);
        write_reg(fbmvn_pkg::CFG_GAIN, 16'hFFFF);
        write_reg(fbmvn_pkg::CFG_SEED, 32'hFFFF_FFFF);
        send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_0001);
        drain();
        write_reg(fbmvn_pkg::CFG_OCTAVES, 15);
        send_point(32'h0003_C000, 32'hFFF0_4000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
        write_reg(fbmvn_pkg::CFG_OCTAVES, 8);
        write_reg(fbmvn_pkg::CFG_LACUN, 12'hFFF);
        write_reg(fbmvn_pkg::CFG_GAIN, 0);
        write_reg(fbmvn_pkg::CFG_SEED, 0);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        for (int i = 0; i < 5; i++) send_point(ext[i], ext[4 - i], ext[i]);
        drain();
        write_reg(fbmvn_pkg::CFG_OCTAVES, 1);
        write_reg(fbmvn_pkg::CFG_LACUN, 256);
        write_reg(fbmvn_pkg::CFG_GAIN, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_point(rand_coord(), rand_coord(), rand_coord());
        drain();
        // random phases with varying idling
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            random_config();
            if (ph == 4) begin
                // receiver holds off while the sender keeps offering
                fork
                    begin hold_off = 1; repeat (150) @(negedge aclk); hold_off = 0; end
                    for (int i = 0; i < 110; i++)
                        send_point(rand_coord(), rand_coord(), rand_coord());
                join
            end else begin
                for (int i = 0; i < 110; i++)
                    send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            if (sb.pending.size() != 0)
                $error("noise_value: %0d results never arrived", sb.pending.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
